>>> rtl/core/kdrs_pkg.sv
`default_nettype none

package kdrs_pkg;

    // Key and relay state codes carried in the key_code field.
    typedef enum logic [2:0] {
        KC_NONE  = 3'd0,
        KC_UP    = 3'd1,
        KC_DOWN  = 3'd2,
        KC_ENTER = 3'd3,
        KC_OPEN  = 3'd4,
        KC_STOP  = 3'd5,
        KC_CLOSE = 3'd6
    } key_code_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_SLAVE_MODE     = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd1;

    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] LIMIT_AT_RESET = 8'd50;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/core/key_debounce_relay_selector_core.sv
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+-----------------------------------------------------
// s_axis   | in        | one scan tick: six active-low key levels
// m_axis   | out       | one result per tick: key code, flags, relay drives
// cfg      | in        | write-only registers: slave_mode, debounce_limit
//
// Each tick is processed combinationally: the debounce counter and key state are
// updated when the tick transfers, and the result lands in the output register.
// A new tick transfers every cycle while the output register is empty or being
// taken in the same cycle, so the sustained rate is one tick per clock.
// A stall on m_axis holds the result and stops intake until it is taken.
// Reset clears the counter, the stored key, the latch and the output valid.
module key_debounce_relay_selector_core
    import kdrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // [0] key_up_level, [1] key_down_level, [2] key_enter_level,
    // [3] key_open_level, [4] key_stop_level, [5] key_close_level, [7:6] zero
    input  wire logic [7:0] s_tdata,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    // [2:0] key_code, [3] new_key, [4] key_held, [5] relay_open,
    // [6] relay_stop, [7] relay_close
    output logic [7:0]      m_tdata,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic             slave_mode_reg;
    logic [CNT_W-1:0] debounce_limit_reg;
    logic [CNT_W-1:0] tick_count_reg;
    logic [CNT_W-1:0] tick_count_next;
    key_code_t        stored_key_reg;
    key_code_t        stored_key_next;
    logic             press_latched_reg;
    logic             press_latched_next;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;

    logic             in_xfer;
    logic             up, down, enter, opn, stp, cls;
    logic             all_high;
    logic [CNT_W-1:0] cnt_inc;
    logic             cnt_fire;
    logic [CNT_W-1:0] cnt_after;
    key_code_t        st_cur;
    key_code_t        tgt_a;
    key_code_t        tgt_b;
    logic             line_a;
    logic             line_b;
    logic             accepted;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign up    = s_tdata[0];
    assign down  = s_tdata[1];
    assign enter = s_tdata[2];
    assign opn   = s_tdata[3];
    assign stp   = s_tdata[4];
    assign cls   = s_tdata[5];
    assign all_high = up && down && enter && opn && stp && cls;

    // Saturating count step; the limit is passed once the count exceeds it.
    assign cnt_inc   = (tick_count_reg == CNT_MAX) ? CNT_MAX : tick_count_reg + 1'b1;
    assign cnt_fire  = cnt_inc > debounce_limit_reg;
    assign cnt_after = cnt_fire ? '0 : cnt_inc;

    // Slave mode: any code other than open or close is treated as stop.
    always_comb
    begin
        st_cur = stored_key_reg;
        if (!(stored_key_reg inside {KC_OPEN, KC_CLOSE}))
        begin
            st_cur = KC_STOP;
        end
        case (st_cur)
            KC_OPEN:
            begin
                tgt_a = KC_STOP;  line_a = stp;
                tgt_b = KC_CLOSE; line_b = cls;
            end
            KC_CLOSE:
            begin
                tgt_a = KC_OPEN;  line_a = opn;
                tgt_b = KC_STOP;  line_b = stp;
            end
            default:
            begin
                tgt_a = KC_OPEN;  line_a = opn;
                tgt_b = KC_CLOSE; line_b = cls;
            end
        endcase
    end

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        stored_key_next    = stored_key_reg;
        press_latched_next = press_latched_reg;
        accepted           = 1'b0;
        m_tdata_next       = '0;

        if (!slave_mode_reg)
        begin
            if (!press_latched_reg && !all_high)
            begin
                tick_count_next = cnt_after;
                if (cnt_fire)
                begin
                    press_latched_next = 1'b1;
                    accepted           = 1'b1;
                    if (!up)
                        stored_key_next = KC_UP;
                    else if (!down)
                        stored_key_next = KC_DOWN;
                    else if (!enter)
                        stored_key_next = KC_ENTER;
                    else if (!opn)
                        stored_key_next = KC_OPEN;
                    else if (!stp)
                        stored_key_next = KC_STOP;
                    else
                        stored_key_next = KC_CLOSE;
                end
            end
            else
            begin
                tick_count_next = '0;
                if (all_high)
                begin
                    press_latched_next = 1'b0;
                end
            end
            m_tdata_next[2:0] = stored_key_next;
            m_tdata_next[3]   = accepted;
            m_tdata_next[4]   = press_latched_next;
        end
        else
        begin
            stored_key_next = st_cur;
            if (line_a && !line_b)
            begin
                tick_count_next = cnt_after;
                if (cnt_fire)
                begin
                    stored_key_next = tgt_a;
                    accepted        = 1'b1;
                end
            end
            else if (!line_a && line_b)
            begin
                tick_count_next = cnt_after;
                if (cnt_fire)
                begin
                    stored_key_next = tgt_b;
                    accepted        = 1'b1;
                end
            end
            else
            begin
                tick_count_next = '0;
            end
            m_tdata_next[2:0] = stored_key_next;
            m_tdata_next[3]   = accepted;
            m_tdata_next[5]   = (stored_key_next == KC_OPEN);
            m_tdata_next[6]   = (stored_key_next == KC_STOP);
            m_tdata_next[7]   = (stored_key_next == KC_CLOSE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_mode_reg     <= 1'b0;
            debounce_limit_reg <= LIMIT_AT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLAVE_MODE:     slave_mode_reg     <= cfg_data[0];
                REG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            stored_key_reg    <= KC_NONE;
            press_latched_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                tick_count_reg    <= tick_count_next;
                stored_key_reg    <= stored_key_next;
                press_latched_reg <= press_latched_next;
                m_tvalid_reg      <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_key_debounce_relay_selector_core.sv
module tb_key_debounce_relay_selector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kdrs_pkg::*;

    // The core decodes only indexes zero and one, so these indexes reach no register.
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    localparam int unsigned LONG_HOLD_CYCLES = 64;
    localparam int unsigned LONG_HOLD_AFTER  = 400;
    localparam int unsigned DRAIN_LIMIT      = 2000;

    typedef struct packed {
        logic close_lvl;
        logic stop_lvl;
        logic open_lvl;
        logic enter_lvl;
        logic down_lvl;
        logic up_lvl;
    } key_levels_t;

    typedef struct packed {
        logic      relay_close;
        logic      relay_stop;
        logic      relay_open;
        logic      key_held;
        logic      new_key;
        key_code_t key_code;
    } tick_result_t;

    localparam key_levels_t ALL_HIGH = '1;

    class key_scoreboard;
        bit           slave_mode;
        logic [7:0]   debounce_limit;
        logic [7:0]   tick_cnt;
        key_code_t    stored;
        bit           latched;
        tick_result_t expected_q[$];
        int unsigned  ticks;
        int unsigned  results;
        int unsigned  presses;
        int unsigned  moves;
        int unsigned  mismatches;

        function new();
            slave_mode     = 1'b0;
            debounce_limit = LIMIT_AT_RESET;
            tick_cnt       = '0;
            stored         = KC_NONE;
            latched        = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                REG_SLAVE_MODE:     slave_mode = data[0];
                REG_DEBOUNCE_LIMIT: debounce_limit = data;
                default: ;
            endcase
        endfunction

        // The counter saturates, so a limit at the counter's top never fires.
        function bit count_exceeds();
            if (tick_cnt != CNT_MAX)
                tick_cnt++;
            if (tick_cnt > debounce_limit)
            begin
                tick_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(key_levels_t lv);
            tick_result_t r;
            key_code_t    st;
            key_code_t    to_a;
            key_code_t    to_b;
            bit           line_a;
            bit           line_b;
            bit           hit;
            r   = '0;
            hit = 1'b0;
            ticks++;
            if (!slave_mode)
            begin
                if (!latched && lv != ALL_HIGH)
                begin
                    if (count_exceeds())
                    begin
                        hit     = 1'b1;
                        latched = 1'b1;
                        if (!lv.up_lvl)
                            stored = KC_UP;
                        else if (!lv.down_lvl)
                            stored = KC_DOWN;
                        else if (!lv.enter_lvl)
                            stored = KC_ENTER;
                        else if (!lv.open_lvl)
                            stored = KC_OPEN;
                        else if (!lv.stop_lvl)
                            stored = KC_STOP;
                        else
                            stored = KC_CLOSE;
                    end
                end
                else
                begin
                    tick_cnt = '0;
                    if (lv == ALL_HIGH)
                        latched = 1'b0;
                end
                r.key_code = stored;
                r.key_held = latched;
                presses += hit;
            end
            else
            begin
                // Anything that is not a relay state is treated as stop.
                st = stored;
                if (st != KC_OPEN && st != KC_CLOSE)
                    st = KC_STOP;
                case (st)
                    KC_OPEN:
                    begin
                        to_a = KC_STOP;  line_a = lv.stop_lvl;
                        to_b = KC_CLOSE; line_b = lv.close_lvl;
                    end
                    KC_STOP:
                    begin
                        to_a = KC_OPEN;  line_a = lv.open_lvl;
                        to_b = KC_CLOSE; line_b = lv.close_lvl;
                    end
                    default:
                    begin
                        to_a = KC_OPEN;  line_a = lv.open_lvl;
                        to_b = KC_STOP;  line_b = lv.stop_lvl;
                    end
                endcase
                if (line_a && !line_b)
                begin
                    if (count_exceeds())
                    begin
                        st  = to_a;
                        hit = 1'b1;
                    end
                end
                else if (!line_a && line_b)
                begin
                    if (count_exceeds())
                    begin
                        st  = to_b;
                        hit = 1'b1;
                    end
                end
                else
                    tick_cnt = '0;
                stored        = st;
                r.key_code    = st;
                r.relay_open  = (st == KC_OPEN);
                r.relay_stop  = (st == KC_STOP);
                r.relay_close = (st == KC_CLOSE);
                moves += hit;
            end
            r.new_key = hit;
            expected_q.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d: %s is %0d, want %0d", results, name, got, want));
        endfunction

        function void check_result(logic [7:0] data);
            tick_result_t got;
            tick_result_t want;
            got = data;
            results++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d (0x%02h) with no tick pending", results, data));
                return;
            end
            want = expected_q.pop_front();
            check_field("key_code", got.key_code, want.key_code);
            check_field("new_key", got.new_key, want.new_key);
            check_field("key_held", got.key_held, want.key_held);
            check_field("relay_open", got.relay_open, want.relay_open);
            check_field("relay_stop", got.relay_stop, want.relay_stop);
            check_field("relay_close", got.relay_close, want.relay_close);
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    key_scoreboard sb = new();
    bit            steady = 1'b0;
    int unsigned   settings = 1;

    key_debounce_relay_selector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_tick(key_levels_t'(s_tdata[5:0]));
        end
    end

    // Result side: short random stalls, plus one long hold so the block backs up.
    initial
    begin : result_sink
        int unsigned hold_left;
        bit          long_done;
        hold_left = 0;
        long_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_done && sb.results >= LONG_HOLD_AFTER)
            begin
                long_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_tick(key_levels_t lv);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, lv};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and let every pending result come out before a register write.
    task automatic settle();
        int unsigned waited;
        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Runs of one level pattern, mostly long enough to pass the debounce limit.
    task automatic run_phase(bit mode, logic [7:0] lim, int unsigned n_ticks);
        int unsigned done;
        int unsigned len;
        key_levels_t pat;
        settle();
        write_reg(REG_SLAVE_MODE, {7'($urandom), mode});
        write_reg(REG_DEBOUNCE_LIMIT, lim);
        settings++;
        done = 0;
        while (done < n_ticks)
        begin
            if (!mode && $urandom_range(0, 3) == 0)
                pat = ALL_HIGH;
            else if (!mode)
                pat = key_levels_t'($urandom_range(0, 62));
            else
                pat = key_levels_t'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, 4);
            else
                len = int'(lim) + $urandom_range(1, 3);
            repeat (len)
            begin
                if (done < n_ticks)
                begin
                    send_tick(pat);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: counting starts but stays below the limit.
        send_tick('0);
        send_tick(ALL_HIGH);

        // Limit zero accepts on the first qualifying tick; spare indexes do nothing.
        settle();
        write_reg(REG_DEBOUNCE_LIMIT, 8'd0);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h01);
        settings++;
        send_tick(ALL_HIGH);
        send_tick('0);
        send_tick('0);
        for (int k = 1; k < 6; k++)
        begin
            send_tick(ALL_HIGH);
            send_tick(key_levels_t'(~(6'd1 << k)));
        end

        // Slave mode picks up the stored key left by host mode.
        settle();
        write_reg(REG_SLAVE_MODE, 8'd1);
        settings++;
        send_tick(6'b001000);
        send_tick(6'b010000);
        send_tick(ALL_HIGH);
        send_tick(6'b100000);

        // A keypad code left in the store is taken as stop.
        settle();
        write_reg(REG_SLAVE_MODE, 8'd0);
        send_tick(ALL_HIGH);
        send_tick(6'b111110);
        settle();
        write_reg(REG_SLAVE_MODE, 8'd1);
        settings += 2;
        send_tick(6'b000111);
        send_tick(6'b001000);

        run_phase(1'b0, 8'd2, 160);
        run_phase(1'b1, 8'd1, 160);
        run_phase(1'b0, 8'd254, 260);
        run_phase(1'b1, 8'd5, 150);
        run_phase(1'b0, 8'd255, 270);
        run_phase(1'b1, 8'd0, 70);
        run_phase(1'b0, 8'd0, 70);
        run_phase(1'b1, 8'd254, 260);
        run_phase(1'b0, LIMIT_AT_RESET, 100);
        steady = 1'b1;
        run_phase(1'b1, 8'($urandom_range(1, 9)), 120);

        settle();
        repeat (8) @(posedge clk);
        sb.check_drained();

        $display("Covered %0d ticks and %0d results over %0d register settings, both modes.",
                 sb.ticks, sb.results, settings);
        $display("Accepted keypad presses: %0d, relay transitions: %0d, mismatches: %0d.",
                 sb.presses, sb.moves, sb.mismatches);
        if (sb.mismatches == 0)
            $display("** key_debounce_relay_selector_core: PASSED **");
        else
            $display("** key_debounce_relay_selector_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("** key_debounce_relay_selector_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/kdrs_pkg.sv
rtl/core/key_debounce_relay_selector_core.sv
dv/tb_key_debounce_relay_selector_core.sv
